// ----- rtl/tcw_pkg.sv -----
package tcw_pkg;

	localparam logic [1:0] ACT_PUT   = 2'd0;
	localparam logic [1:0] ACT_CLEAR = 2'd1;
	localparam logic [1:0] ACT_MOVE  = 2'd2;
	localparam logic [1:0] ACT_READ  = 2'd3;

	localparam logic [7:0] CH_LF       = 8'd10;
	localparam logic [7:0] CH_CR       = 8'd13;
	localparam logic [7:0] CH_BLANK    = 8'h20;
	localparam logic [7:0] RESET_COLOR = 8'h0F;

	// widest column and row over the supported geometries
	localparam int CMD_COL_W = 7;
	localparam int CMD_ROW_W = 6;

	typedef struct packed {
		logic [1:0] action;
		logic [7:0] char_code;
		logic [7:0] pos_col;
		logic [7:0] pos_row;
	} in_item_t;

	typedef struct packed {
		logic [7:0] cell_char;
		logic [7:0] cell_attr;
		logic [4:0] cursor_row;
		logic [6:0] cursor_col;
	} out_item_t;

	typedef enum logic [2:0] {
		OP_PUT,
		OP_NEWLINE,
		OP_RETURN,
		OP_CLEAR,
		OP_MOVE,
		OP_READ
	} cmd_op_t;

	typedef struct packed {
		cmd_op_t              op;
		logic [7:0]           ch;
		logic [CMD_COL_W-1:0] col;
		logic [CMD_ROW_W-1:0] row;
		logic [CMD_ROW_W-1:0] scroll_n;
		logic                 full_blank;
		logic                 in_range;
	} cmd_t;

endpackage

// ----- rtl/tcw_ram.sv -----
module tcw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- rtl/tcw_front.sv -----
module tcw_front #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  tcw_pkg::in_item_t in_data,
	input  logic             init_done,
	output logic             push,
	output tcw_pkg::cmd_t    cmd,
	input  logic             q_full
);

	import tcw_pkg::*;

	// reciprocal for the column split, exact after one correction step
	localparam int RECIP = (1 << 16) / COLUMNS;

	logic       valid_s1, valid_s2, valid_s3;
	in_item_t   item_s1, item_s2, item_s3;
	logic [7:0] q_est_s1, q_est_s2;
	logic [8:0] rem_s2;
	logic [6:0] col_s3;
	logic [8:0] y_s3;

	logic        en1, en2, en3;
	logic [23:0] prod;
	logic [15:0] qc;
	logic        corr;
	logic [8:0]  rem_fix;
	logic        over, full;
	logic [8:0]  n_full;

	assign en3 = !valid_s3 || push;
	assign en2 = !valid_s2 || en3;
	assign en1 = (!valid_s1 || en2) && init_done;
	assign in_stall = !en1;
	assign push = valid_s3 && !q_full;

	assign prod = {16'b0, in_data.pos_col} * 24'(RECIP);
	assign qc = 16'(q_est_s1) * 16'(COLUMNS);
	assign corr = rem_s2 >= 9'(COLUMNS);
	assign rem_fix = corr ? rem_s2 - 9'(COLUMNS) : rem_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (en1) valid_s1 <= in_valid;
			if (en2) valid_s2 <= valid_s1;
			if (en3) valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			item_s1  <= in_data;
			q_est_s1 <= prod[23:16];
		end
		if (en2) begin
			item_s2  <= item_s1;
			q_est_s2 <= q_est_s1;
			rem_s2   <= {1'b0, item_s1.pos_col} - qc[8:0];
		end
		if (en3) begin
			item_s3 <= item_s2;
			col_s3  <= 7'(rem_fix);
			y_s3    <= {1'b0, item_s2.pos_row} + {1'b0, q_est_s2} + {8'b0, corr};
		end
	end

	assign over = y_s3 >= 9'(ROWS);
	assign full = y_s3 >= 9'(2 * ROWS - 1);
	assign n_full = y_s3 - 9'(ROWS - 1);

	always_comb begin
		cmd = '0;
		cmd.op = OP_PUT;
		cmd.ch = item_s3.char_code;
		case (item_s3.action)
			ACT_PUT: begin
				if (item_s3.char_code == CH_LF) begin
					cmd.op = OP_NEWLINE;
				end else if (item_s3.char_code == CH_CR) begin
					cmd.op = OP_RETURN;
				end else begin
					cmd.op = OP_PUT;
				end
			end
			ACT_CLEAR: begin
				cmd.op = OP_CLEAR;
			end
			ACT_MOVE: begin
				cmd.op = OP_MOVE;
				cmd.col = CMD_COL_W'(col_s3);
				cmd.row = over ? CMD_ROW_W'(ROWS - 1) : CMD_ROW_W'(y_s3);
				cmd.scroll_n = (over && !full) ? CMD_ROW_W'(n_full) : '0;
				cmd.full_blank = full;
			end
			ACT_READ: begin
				cmd.op = OP_READ;
				cmd.col = CMD_COL_W'(item_s3.pos_col);
				cmd.row = CMD_ROW_W'(item_s3.pos_row);
				cmd.in_range = ({1'b0, item_s3.pos_col} < 9'(COLUMNS)) &&
					({1'b0, item_s3.pos_row} < 9'(ROWS));
			end
			default: begin
				cmd.op = OP_PUT;
			end
		endcase
	end

endmodule

// ----- rtl/tcw_cmd_fifo.sv -----
module tcw_cmd_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  tcw_pkg::cmd_t push_cmd,
	output logic          full,
	input  logic          pop,
	output tcw_pkg::cmd_t pop_cmd,
	output logic          empty
);

	import tcw_pkg::*;

	cmd_t       mem_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;

	assign full = count_q == 2'd2;
	assign empty = count_q == 2'd0;
	assign pop_cmd = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop) rd_ptr_q <= !rd_ptr_q;
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

// ----- rtl/tcw_back.sv -----
module tcw_back #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	input  tcw_pkg::cmd_t      cmd,
	output logic               cmd_pop,
	input  logic [7:0]         text_color,
	output logic               init_done,
	output logic               out_valid,
	input  logic               out_stall,
	output tcw_pkg::out_item_t out_data
);

	import tcw_pkg::*;

	localparam int CELLS = COLUMNS * ROWS;
	localparam int AW = $clog2(CELLS);
	localparam int CW = $clog2(COLUMNS);
	localparam int RW = $clog2(ROWS);

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_SCROLL,
		ST_FILL,
		ST_READ_AD,
		ST_READ_RQ,
		ST_READ_WT,
		ST_FINISH
	} state_t;

	state_t          state_q;
	logic [RW-1:0]   cur_row_q, cur_prow_q, top_q, scroll_left_q;
	logic [CW-1:0]   cur_col_q, rd_col_q;
	logic [RW-1:0]   rd_row_q, rd_prow_q;
	logic [AW-1:0]   fill_addr_q, fill_end_q, rd_addr_q;
	logic            rd_hit_q;
	logic            out_valid_q;
	out_item_t       out_data_q;

	logic            we;
	logic [AW-1:0]   waddr;
	logic [15:0]     wdata;
	logic [15:0]     rdata;
	logic [AW-1:0]   cur_addr, top_base;

	// top_q is the physical line that shows as row 0
	function automatic logic [RW-1:0] row_wrap(input logic [RW-1:0] a, input logic [RW-1:0] b);
		logic [RW:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= (RW + 1)'(ROWS)) begin
			s = s - (RW + 1)'(ROWS);
		end
		return s[RW-1:0];
	endfunction

	assign cur_addr = AW'(cur_prow_q) * AW'(COLUMNS) + AW'(cur_col_q);
	assign top_base = AW'(top_q) * AW'(COLUMNS);
	assign cmd_pop = (state_q == ST_IDLE) && cmd_valid;
	assign init_done = state_q != ST_INIT;
	assign out_valid = out_valid_q;
	assign out_data = out_data_q;

	always_comb begin
		we = 1'b0;
		waddr = fill_addr_q;
		wdata = {text_color, CH_BLANK};
		case (state_q)
			ST_INIT: begin
				we = 1'b1;
				wdata = {RESET_COLOR, CH_BLANK};
			end
			ST_FILL: begin
				we = 1'b1;
			end
			ST_IDLE: begin
				we = cmd_valid && (cmd.op == OP_PUT);
				waddr = cur_addr;
				wdata = {text_color, cmd.ch};
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	tcw_ram #(
		.WIDTH(16),
		.DEPTH(CELLS)
	) u_screen (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(rd_addr_q),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_INIT;
			cur_row_q     <= '0;
			cur_col_q     <= '0;
			cur_prow_q    <= '0;
			top_q         <= '0;
			scroll_left_q <= '0;
			fill_addr_q   <= '0;
			fill_end_q    <= AW'(CELLS - 1);
			rd_row_q      <= '0;
			rd_col_q      <= '0;
			rd_prow_q     <= '0;
			rd_addr_q     <= '0;
			rd_hit_q      <= 1'b0;
			out_valid_q   <= 1'b0;
			out_data_q    <= '0;
		end else begin
			// in ST_FINISH the result register is handled below
			if (out_valid_q && !out_stall && state_q != ST_FINISH) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_INIT: begin
					if (fill_addr_q == fill_end_q) begin
						state_q <= ST_IDLE;
					end else begin
						fill_addr_q <= fill_addr_q + AW'(1);
					end
				end
				ST_IDLE: begin
					if (cmd_valid) begin
						rd_hit_q <= (cmd.op == OP_READ) && cmd.in_range;
						case (cmd.op)
							OP_PUT, OP_NEWLINE: begin
								if (cmd.op == OP_PUT && cur_col_q != CW'(COLUMNS - 1)) begin
									cur_col_q <= cur_col_q + CW'(1);
									state_q <= ST_FINISH;
								end else begin
									cur_col_q <= '0;
									if (cur_row_q == RW'(ROWS - 1)) begin
										scroll_left_q <= RW'(1);
										state_q <= ST_SCROLL;
									end else begin
										cur_row_q <= cur_row_q + RW'(1);
										state_q <= ST_FINISH;
									end
								end
							end
							OP_RETURN: begin
								cur_col_q <= '0;
								state_q <= ST_FINISH;
							end
							OP_CLEAR: begin
								cur_row_q <= '0;
								cur_col_q <= '0;
								scroll_left_q <= '0;
								fill_addr_q <= '0;
								fill_end_q <= AW'(CELLS - 1);
								state_q <= ST_FILL;
							end
							OP_MOVE: begin
								cur_row_q <= RW'(cmd.row);
								cur_col_q <= CW'(cmd.col);
								if (cmd.full_blank) begin
									scroll_left_q <= '0;
									fill_addr_q <= '0;
									fill_end_q <= AW'(CELLS - 1);
									state_q <= ST_FILL;
								end else begin
									scroll_left_q <= RW'(cmd.scroll_n);
									state_q <= (cmd.scroll_n != '0) ? ST_SCROLL : ST_FINISH;
								end
							end
							OP_READ: begin
								rd_row_q <= RW'(cmd.row);
								rd_col_q <= CW'(cmd.col);
								state_q <= cmd.in_range ? ST_READ_AD : ST_FINISH;
							end
							default: begin
								state_q <= ST_FINISH;
							end
						endcase
					end
				end
				ST_SCROLL: begin
					// the old top line becomes the new bottom line, blanked
					fill_addr_q <= top_base;
					fill_end_q <= top_base + AW'(COLUMNS - 1);
					top_q <= row_wrap(top_q, RW'(1));
					scroll_left_q <= scroll_left_q - RW'(1);
					state_q <= ST_FILL;
				end
				ST_FILL: begin
					if (fill_addr_q == fill_end_q) begin
						state_q <= (scroll_left_q != '0) ? ST_SCROLL : ST_FINISH;
					end else begin
						fill_addr_q <= fill_addr_q + AW'(1);
					end
				end
				ST_READ_AD: begin
					rd_prow_q <= row_wrap(rd_row_q, top_q);
					state_q <= ST_READ_RQ;
				end
				ST_READ_RQ: begin
					rd_addr_q <= AW'(rd_prow_q) * AW'(COLUMNS) + AW'(rd_col_q);
					state_q <= ST_READ_WT;
				end
				ST_READ_WT: begin
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					cur_prow_q <= row_wrap(cur_row_q, top_q);
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						out_data_q.cell_char <= rd_hit_q ? rdata[7:0] : 8'd0;
						out_data_q.cell_attr <= rd_hit_q ? rdata[15:8] : 8'd0;
						out_data_q.cursor_row <= 5'(cur_row_q);
						out_data_q.cursor_col <= 7'(cur_col_q);
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- rtl/text_console_writer.sv -----
// channel  dir  handshake              payload
// in       in   in_valid / in_stall    tcw_pkg::in_item_t, one action
// out      out  out_valid / out_stall  tcw_pkg::out_item_t, one per action
// cfg      in   cfg_we                 cfg_wdata, text colour byte
//
// the front takes an item each cycle unless stalled, into a three-stage classifier and a
// two-entry queue; the back runs one command at a time: put, return, move: idle, finish;
// read: address, request, wait; each scrolled line: scroll, fill; clear fills all cells
// after reset a clearing pass writes COLUMNS*ROWS cells (2000 by default), inputs held off
// out_stall only blocks the result register; the back keeps working until its next result
module text_console_writer #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  tcw_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output tcw_pkg::out_item_t out_data,
	input  logic               cfg_we,
	input  logic [7:0]         cfg_wdata
);

	import tcw_pkg::*;

	logic [7:0] text_color_q;
	logic       init_done;
	logic       q_push, q_pop, q_full, q_empty;
	cmd_t       push_cmd, pop_cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_color_q <= RESET_COLOR;
		end else if (cfg_we) begin
			text_color_q <= cfg_wdata;
		end
	end

	tcw_front #(
		.COLUMNS(COLUMNS),
		.ROWS   (ROWS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.init_done(init_done),
		.push     (q_push),
		.cmd      (push_cmd),
		.q_full   (q_full)
	);

	tcw_cmd_fifo u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.push_cmd(push_cmd),
		.full    (q_full),
		.pop     (q_pop),
		.pop_cmd (pop_cmd),
		.empty   (q_empty)
	);

	tcw_back #(
		.COLUMNS(COLUMNS),
		.ROWS   (ROWS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (!q_empty),
		.cmd       (pop_cmd),
		.cmd_pop   (q_pop),
		.text_color(text_color_q),
		.init_done (init_done),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	a_queue_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("command pushed into a full queue");

	a_queue_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("command popped from an empty queue");

	a_cursor_on_screen: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ({1'b0, out_data.cursor_col} < 8'(COLUMNS)) &&
			({2'b0, out_data.cursor_row} < 7'(ROWS)))
		else $error("reported cursor off screen");

	a_no_transfer_during_init: assert property (@(posedge clk) disable iff (!arst_n)
		!init_done |-> in_stall && !q_pop)
		else $error("transfer taken during the clearing pass");

endmodule
